@@ rtl/core/cc20_pkg.sv @@
package cc20_pkg;

   // block geometry
   localparam int unsigned WORD_W       = 32;
   localparam int unsigned WORDS        = 16;
   localparam int unsigned POS_W        = 7;
   localparam int unsigned ROUND_CYCLES = 80;
   localparam int unsigned CYC_W        = $clog2(ROUND_CYCLES);

   localparam logic [POS_W-1:0] POS_EMPTY  = POS_W'(64);
   localparam logic [CYC_W-1:0] CYC_LAST   = CYC_W'(ROUND_CYCLES - 1);

   // the four sigma words, word 0 in the low bits
   localparam logic [3:0][WORD_W-1:0] SIGMA = {
      32'h6B206574, 32'h79622D32, 32'h3320646E, 32'h61707865
   };

   // register indexes of the csr port
   localparam logic [2:0] CSR_KEY_0_1   = 3'd0;
   localparam logic [2:0] CSR_KEY_2_3   = 3'd1;
   localparam logic [2:0] CSR_KEY_4_5   = 3'd2;
   localparam logic [2:0] CSR_KEY_6_7   = 3'd3;
   localparam logic [2:0] CSR_START_CNT = 3'd4;
   localparam logic [2:0] CSR_NONCE_0_1 = 3'd5;
   localparam logic [2:0] CSR_NONCE_2   = 3'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GEN,
      ST_EMIT
   } top_state_type;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_ROUND,
      CORE_FINAL
   } core_state_type;

   // block inputs, word 0 of each group in the low bits
   typedef struct packed {
      logic [7:0][WORD_W-1:0] key;
      logic [WORD_W-1:0]      counter;
      logic [2:0][WORD_W-1:0] nonce;
   } cc20_init_type;

   typedef struct packed {
      logic done;
   } cc20_core_stat_type;

   // state word index for a row of a quarter round, column or diagonal form
   function automatic logic [3:0] lane_idx(input logic [1:0] row,
                                           input logic [1:0] lane,
                                           input logic       diag);
      logic [1:0] col;
      col = diag ? 2'(lane + row) : lane;
      return {row, col};
   endfunction

   // rotation of each of the four quarter-round steps
   function automatic logic [4:0] rot_amount(input logic [1:0] step);
      logic [4:0] amt;
      case (step)
         2'd0:    amt = 5'd16;
         2'd1:    amt = 5'd12;
         2'd2:    amt = 5'd8;
         default: amt = 5'd7;
      endcase
      return amt;
   endfunction

endpackage

@@ rtl/core/cc20_req_if.sv @@
interface cc20_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

@@ rtl/core/cc20_rsp_if.sv @@
interface cc20_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ rtl/core/cc20_qr_step.sv @@
module cc20_qr_step (
   input  logic [31:0] x_word,
   input  logic [31:0] y_word,
   input  logic [31:0] z_word,
   input  logic [4:0]  rot,
   output logic [31:0] x_sum,
   output logic [31:0] z_rot
);
   import cc20_pkg::*;

   logic [WORD_W-1:0] mix;

   // one add, xor and rotate step of a quarter round
   assign x_sum = x_word + y_word;
   assign mix   = z_word ^ x_sum;
   assign z_rot = (mix << rot) | (mix >> (6'd32 - {1'b0, rot}));

endmodule

@@ rtl/core/cc20_block.sv @@
module cc20_block (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  cc20_pkg::cc20_init_type           init,
   output cc20_pkg::cc20_core_stat_type      stat,
   output logic [15:0][31:0]                 ks_words
);
   import cc20_pkg::*;

   core_state_type                 state_ff, state_in;
   logic [WORDS-1:0][WORD_W-1:0]   w_ff, w_in;
   logic [WORDS-1:0][WORD_W-1:0]   init_ff, init_in;
   logic [CYC_W-1:0]               cyc_ff, cyc_in;
   logic [WORDS-1:0][WORD_W-1:0]   init_words;

   logic [1:0]                     step;
   logic                           diag;
   logic [4:0]                     rot;
   logic [3:0][3:0]                x_idx, y_idx, z_idx;
   logic [3:0][WORD_W-1:0]         lane_x, lane_z;

   // initial state: sigma, key, counter, nonce
   assign init_words = {init.nonce, init.counter, init.key, SIGMA};

   // round sequencing: four steps per round, odd rounds are diagonal
   assign step = cyc_ff[1:0];
   assign diag = cyc_ff[2];
   assign rot  = rot_amount(step);

   // four quarter-round lanes, one step each per cycle
   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [3:0] a_idx, b_idx, c_idx, d_idx;

      assign a_idx = lane_idx(2'd0, 2'(l), diag);
      assign b_idx = lane_idx(2'd1, 2'(l), diag);
      assign c_idx = lane_idx(2'd2, 2'(l), diag);
      assign d_idx = lane_idx(2'd3, 2'(l), diag);

      assign x_idx[l] = step[0] ? c_idx : a_idx;
      assign y_idx[l] = step[0] ? d_idx : b_idx;
      assign z_idx[l] = step[0] ? b_idx : d_idx;

      cc20_qr_step u_step (
         .x_word (w_ff[x_idx[l]]),
         .y_word (w_ff[y_idx[l]]),
         .z_word (w_ff[z_idx[l]]),
         .rot    (rot),
         .x_sum  (lane_x[l]),
         .z_rot  (lane_z[l])
      );
   end

   // sequencer and state update
   always_comb begin
      state_in  = state_ff;
      w_in      = w_ff;
      init_in   = init_ff;
      cyc_in    = cyc_ff;
      stat.done = 1'b0;
      case (state_ff)
         CORE_IDLE: begin
            if (start) begin
               w_in     = init_words;
               init_in  = init_words;
               cyc_in   = '0;
               state_in = CORE_ROUND;
            end
         end
         CORE_ROUND: begin
            for (int l = 0; l < 4; l++) begin
               w_in[x_idx[l]] = lane_x[l];
               w_in[z_idx[l]] = lane_z[l];
            end
            cyc_in = cyc_ff + CYC_W'(1);
            if (cyc_ff == CYC_LAST) begin
               state_in = CORE_FINAL;
            end
         end
         CORE_FINAL: begin
            for (int i = 0; i < WORDS; i++) begin
               w_in[i] = w_ff[i] + init_ff[i];
            end
            stat.done = 1'b1;
            state_in  = CORE_IDLE;
         end
         default: begin
            state_in = CORE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working state doubles as the keystream buffer once finished
   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      init_ff <= init_in;
      cyc_ff  <= cyc_in;
   end

   assign ks_words = w_ff;

endmodule

@@ rtl/core/chacha20_stream_cipher_core.sv @@
// ChaCha20 stream cipher (IETF layout), one byte per transfer.
// req_chan carries data_byte and last; rsp_chan returns out_byte, which is
// data_byte XOR the next keystream byte, and out_last, a copy of last.
// The csr port (csr_wr_en, csr_index, csr_wr_data) loads the key, nonce and
// start counter; writing the start counter reloads the running block counter.
// Write it only while the block is idle.
// A byte served from the buffered keystream block appears on rsp_chan in
// the cycle after its transfer, so one byte per cycle while a block lasts
// and the receiver does not stall. When the buffer is empty a new 64-byte
// block is made first: the rounds on the shared quarter-round unit (4 lanes,
// one add/xor/rotate step each per cycle), then the final addition, then the
// emit state, which waits for a free output slot. No new byte is taken while
// a block is made. A byte with last set drops the rest of its block.
// Reset zeroes the key, nonce and block counter registers and empties the buffer.
// If the receiver stalls, the result holds in the output register and no
// further byte is taken until it has been transferred.
module chacha20_stream_cipher_core (
   input  logic             clock,
   input  logic             reset,
   cc20_req_if.sink         req_chan,
   cc20_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wr_data
);
   import cc20_pkg::*;

   top_state_type           state_ff, state_in;
   logic [3:0][63:0]        key_ff, key_in;
   logic [63:0]             nonce01_ff, nonce01_in;
   logic [WORD_W-1:0]       nonce2_ff, nonce2_in;
   logic [WORD_W-1:0]       counter_ff, counter_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [7:0]              hold_byte_ff, hold_byte_in;
   logic                    hold_last_ff, hold_last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_byte_ff, rsp_byte_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    slot_free;
   logic                    accept;
   logic                    core_start;
   cc20_init_type           core_init;
   cc20_core_stat_type      core_stat;
   logic [WORDS-1:0][WORD_W-1:0] ks_words;
   logic [WORD_W-1:0]       ks_word;
   logic [WORD_W-1:0]       ks_shift;
   logic [7:0]              ks_byte;

   // block function unit
   assign core_init.key     = key_ff;
   assign core_init.counter = counter_ff;
   assign core_init.nonce   = {nonce2_ff, nonce01_ff};

   cc20_block u_block (
      .clock    (clock),
      .reset    (reset),
      .start    (core_start),
      .init     (core_init),
      .stat     (core_stat),
      .ks_words (ks_words)
   );

   // keystream byte at the current position
   assign ks_word  = ks_words[pos_ff[5:2]];
   assign ks_shift = ks_word >> {pos_ff[1:0], 3'b000};
   assign ks_byte  = ks_shift[7:0];

   // handshake
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && slot_free;
   assign accept         = req_chan.valid && req_chan.ready;

   // csr writes
   always_comb begin
      key_in     = key_ff;
      nonce01_in = nonce01_ff;
      nonce2_in  = nonce2_ff;
      counter_in = counter_ff;
      if (core_start) begin
         counter_in = counter_ff + WORD_W'(1);
      end
      if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_0_1:   key_in[0]  = csr_wr_data;
            CSR_KEY_2_3:   key_in[1]  = csr_wr_data;
            CSR_KEY_4_5:   key_in[2]  = csr_wr_data;
            CSR_KEY_6_7:   key_in[3]  = csr_wr_data;
            CSR_START_CNT: counter_in = csr_wr_data[WORD_W-1:0];
            CSR_NONCE_0_1: nonce01_in = csr_wr_data;
            CSR_NONCE_2:   nonce2_in  = csr_wr_data[WORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // byte sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      hold_byte_in = hold_byte_ff;
      hold_last_in = hold_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      core_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (pos_ff[POS_W-1]) begin
                  // buffer empty: park the byte and make a block
                  hold_byte_in = req_chan.data_byte;
                  hold_last_in = req_chan.last;
                  core_start   = 1'b1;
                  state_in     = ST_GEN;
               end else begin
                  rsp_byte_in  = req_chan.data_byte ^ ks_byte;
                  rsp_last_in  = req_chan.last;
                  rsp_valid_in = 1'b1;
                  pos_in       = req_chan.last ? POS_EMPTY : pos_ff + POS_W'(1);
               end
            end
         end
         ST_GEN: begin
            if (core_stat.done) begin
               pos_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_byte_in  = hold_byte_ff ^ ks_byte;
               rsp_last_in  = hold_last_ff;
               rsp_valid_in = 1'b1;
               pos_in       = hold_last_ff ? POS_EMPTY : pos_ff + POS_W'(1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= POS_EMPTY;
         counter_ff   <= '0;
         key_ff       <= '0;
         nonce01_ff   <= '0;
         nonce2_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         counter_ff   <= counter_in;
         key_ff       <= key_in;
         nonce01_ff   <= nonce01_in;
         nonce2_ff    <= nonce2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
      hold_last_ff <= hold_last_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.out_last = rsp_last_ff;

endmodule

@@ tb/sv/cc20_cipher_check_pkg.sv @@
`timescale 1ns / 100ps
package cc20_cipher_check_pkg;

   import cc20_pkg::*;

   // expansion constant, word 0 first
   localparam logic [31:0] EXPAND_WORDS [4] = '{
      32'h61707865, 32'h3320646E, 32'h79622D32, 32'h6B206574
   };
   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned DOUBLE_RNDS = 10;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } cipher_out_type;

   // keystream predictor and store of expected output bytes
   class cipher_byte_checker;
      logic [63:0]     csr_copy [7];
      logic [31:0]     ks_word [16];
      logic [31:0]     mix [16];
      int unsigned     ks_pos;
      logic [31:0]     blk_count;
      cipher_out_type  expected_bytes [$];
      int unsigned     errors;
      int unsigned     bytes_checked;
      int unsigned     blocks_made;

      function new();
         foreach (csr_copy[i]) csr_copy[i] = '0;
         foreach (ks_word[i]) ks_word[i] = '0;
         ks_pos        = BLOCK_BYTES;
         blk_count     = '0;
         errors        = 0;
         bytes_checked = 0;
         blocks_made   = 0;
      endfunction

      function int unsigned pending();
         return expected_bytes.size();
      endfunction

      // register write, masked to the register width
      function void write_register(logic [2:0] idx, logic [63:0] val);
         case (idx)
            CSR_START_CNT: begin
               csr_copy[idx] = {32'h0, val[31:0]};
               blk_count     = val[31:0];
            end
            CSR_NONCE_2: begin
               csr_copy[idx] = {32'h0, val[31:0]};
            end
            CSR_KEY_0_1, CSR_KEY_2_3, CSR_KEY_4_5, CSR_KEY_6_7, CSR_NONCE_0_1: begin
               csr_copy[idx] = val;
            end
            default: begin
            end
         endcase
      endfunction

      function logic [31:0] rotl(logic [31:0] v, int n);
         return (v << n) | (v >> (32 - n));
      endfunction

      function void quarter_round(int a, int b, int c, int d);
         mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
         mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
         mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
         mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
      endfunction

      // one 64-byte keystream block from the current key, counter and nonce
      function void gen_keystream_block();
         logic [31:0] init_w [16];
         for (int i = 0; i < 4; i++) init_w[i] = EXPAND_WORDS[i];
         for (int i = 0; i < 4; i++) begin
            init_w[4 + 2*i] = csr_copy[i][31:0];
            init_w[5 + 2*i] = csr_copy[i][63:32];
         end
         init_w[12] = blk_count;
         init_w[13] = csr_copy[CSR_NONCE_0_1][31:0];
         init_w[14] = csr_copy[CSR_NONCE_0_1][63:32];
         init_w[15] = csr_copy[CSR_NONCE_2][31:0];
         mix = init_w;
         for (int r = 0; r < DOUBLE_RNDS; r++) begin
            quarter_round(0, 4, 8, 12);
            quarter_round(1, 5, 9, 13);
            quarter_round(2, 6, 10, 14);
            quarter_round(3, 7, 11, 15);
            quarter_round(0, 5, 10, 15);
            quarter_round(1, 6, 11, 12);
            quarter_round(2, 7, 8, 13);
            quarter_round(3, 4, 9, 14);
         end
         for (int i = 0; i < 16; i++) ks_word[i] = mix[i] + init_w[i];
         blk_count   = blk_count + 32'd1;
         ks_pos      = 0;
         blocks_made++;
      endfunction

      // accepted input byte: work out its output
      function void predict_byte(logic [7:0] data_byte, logic last);
         logic [31:0]    w;
         cipher_out_type e;
         if (ks_pos >= BLOCK_BYTES) gen_keystream_block();
         w = ks_word[ks_pos / 4];
         e.out_byte = data_byte ^ w[8*(ks_pos % 4) +: 8];
         e.out_last = last;
         expected_bytes.push_back(e);
         // last byte drops the rest of the block
         ks_pos = last ? BLOCK_BYTES : ks_pos + 1;
      endfunction

      // accepted output byte against the oldest expectation
      function void check_byte(logic [7:0] out_byte, logic out_last);
         cipher_out_type e;
         if (expected_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected output byte %02h last %0b", $time, out_byte, out_last);
         end else begin
            e = expected_bytes.pop_front();
            bytes_checked++;
            if (e.out_byte !== out_byte) begin
               errors++;
               $display("%0t: out_byte expected %02h actual %02h", $time, e.out_byte,
                        out_byte);
            end
            if (e.out_last !== out_last) begin
               errors++;
               $display("%0t: out_last expected %0b actual %0b", $time, e.out_last,
                        out_last);
            end
         end
      endfunction
   endclass

endpackage

@@ tb/sv/chacha20_stream_cipher_core_tb.sv @@
`timescale 1ns / 100ps
module chacha20_stream_cipher_core_tb;

   import cc20_pkg::*;
   import cc20_cipher_check_pkg::*;

   // index with no register behind it
   localparam logic [2:0]  CSR_NONE     = 3'd7;
   localparam logic [2:0]  CSR_LIST [7] = '{
      CSR_KEY_0_1, CSR_KEY_2_3, CSR_KEY_4_5, CSR_KEY_6_7,
      CSR_START_CNT, CSR_NONCE_0_1, CSR_NONCE_2
   };
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned TARGET_ITEMS = 800;
   localparam int unsigned CALM_FROM    = 700;
   localparam int unsigned TAIL_CYCLES  = 200;
   localparam int unsigned DRAIN_LIMIT  = 20000;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [63:0] csr_wr_data;

   cc20_req_if req_chan ();
   cc20_rsp_if rsp_chan ();

   cipher_byte_checker cipher_sb;

   bit          calm;
   bit          quiet;
   bit          hold_req;
   int unsigned items_sent;
   int unsigned msgs_sent;
   int unsigned settings_used;

   chacha20_stream_cipher_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   initial begin
      #3000000;
      $display("DONE: errors detected");
      $finish;
   end

   // transfer monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            cipher_sb.predict_byte(req_chan.data_byte, req_chan.last);
         if (rsp_chan.valid && rsp_chan.ready)
            cipher_sb.check_byte(rsp_chan.out_byte, rsp_chan.out_last);
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      int unsigned n;
      rsp_chan.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_req = 1'b0;
         end else if (!calm && !quiet && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready = 1'b0;
            n = $urandom_range(1, 12);
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // offer one byte and wait for its transfer
   task automatic send_byte(input logic [7:0] data_byte, input logic last);
      @(negedge clock);
      req_chan.valid     = 1'b1;
      req_chan.data_byte = data_byte;
      req_chan.last      = last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
      if (items_sent >= CALM_FROM) calm = 1'b1;
   endtask

   // sender gap with valid low, junk on the payload
   task automatic sender_idle(input int unsigned n);
      @(negedge clock);
      req_chan.valid     = 1'b0;
      req_chan.data_byte = 8'($urandom);
      req_chan.last      = 1'($urandom);
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_message(input int unsigned len, input bit end_flag);
      logic l;
      for (int unsigned i = 0; i < len; i++) begin
         l = (i == len - 1) ? end_flag : ($urandom_range(0, 40) == 0);
         send_byte(8'($urandom_range(0, 255)), l);
         if (!calm && !quiet && $urandom_range(0, 5) == 0)
            sender_idle($urandom_range(1, 12));
      end
   endtask

   // stop offering until every expected byte is back
   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (cipher_sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = val;
      cipher_sb.write_register(idx, val);
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   function automatic logic [63:0] pick_word64();
      logic [63:0] v;
      case ($urandom_range(0, 5))
         0:       v = '0;
         1:       v = '1;
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // a random setting: some registers rewritten, extremes favoured
   task automatic load_random_setting();
      logic [63:0] v;
      foreach (CSR_LIST[i]) begin
         if ($urandom_range(0, 2) != 0) begin
            v = pick_word64();
            if (CSR_LIST[i] == CSR_START_CNT) begin
               case ($urandom_range(0, 3))
                  0: v[31:0] = 32'hFFFF_FFFF;
                  1: v[31:0] = 32'hFFFF_FFFE;
                  default: begin
                  end
               endcase
            end
            write_csr(CSR_LIST[i], v);
         end
      end
      if ($urandom_range(0, 7) == 0) write_csr(CSR_NONE, pick_word64());
      settings_used++;
   endtask

   initial begin
      int unsigned budget;
      int unsigned len;
      int unsigned n;
      int unsigned r;

      cipher_sb          = new();
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_KEY_0_1;
      csr_wr_data        = '0;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last      = 1'b0;
      calm               = 1'b0;
      quiet              = 1'b0;
      hold_req           = 1'b0;
      items_sent         = 0;
      msgs_sent          = 0;
      settings_used      = 1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all-zero setting after reset, byte extremes, last mid-block
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hA5, 1'b1);
      send_byte(8'h3C, 1'b1);
      send_byte(8'hC3, 1'b0);
      drain();

      // counter wrap with junk in the upper half, every register written
      write_csr(CSR_KEY_0_1, 64'h0706_0504_0302_0100);
      write_csr(CSR_KEY_2_3, 64'h0F0E_0D0C_0B0A_0908);
      write_csr(CSR_KEY_4_5, 64'h1716_1514_1312_1110);
      write_csr(CSR_KEY_6_7, 64'h1F1E_1D1C_1B1A_1918);
      write_csr(CSR_START_CNT, 64'hDEAD_BEEF_FFFF_FFFF);
      write_csr(CSR_NONCE_0_1, 64'h4A00_0000_0900_0000);
      write_csr(CSR_NONCE_2, 64'h1234_5678_0000_0000);
      write_csr(CSR_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
      settings_used++;
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h81, 1'b1);
      send_byte(8'h7E, 1'b0);
      send_byte(8'h11, 1'b0);
      drain();

      // all-ones key and nonce, counter runs on
      foreach (CSR_LIST[i])
         if (CSR_LIST[i] != CSR_START_CNT) write_csr(CSR_LIST[i], '1);
      settings_used++;
      repeat (4) send_byte(8'($urandom), 1'b0);
      drain();
      // key change must not flush the buffered block
      write_csr(CSR_KEY_0_1, '0);
      settings_used++;
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFE, 1'b1);
      send_byte(8'h7F, 1'b0);
      msgs_sent = 9;

      // random phases of messages
      while (items_sent < TARGET_ITEMS) begin
         drain();
         load_random_setting();
         quiet = ($urandom_range(0, 3) == 0);
         if (settings_used == 5) hold_req = 1'b1;
         budget = items_sent + $urandom_range(40, 90);
         while (items_sent < budget && items_sent < TARGET_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 4)      len = $urandom_range(1, 8);
            else if (r < 8) len = $urandom_range(9, 70);
            else            len = $urandom_range(64, 200);
            send_message(len, $urandom_range(0, 7) != 0);
            msgs_sent++;
         end
      end

      // wind down
      @(negedge clock);
      req_chan.valid = 1'b0;
      n = 0;
      while (cipher_sb.pending() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (cipher_sb.pending() != 0) begin
         $display("%0t: %0d expected bytes never came out", $time, cipher_sb.pending());
         cipher_sb.errors += cipher_sb.pending();
      end

      $display("run covered %0d bytes in %0d messages under %0d key settings, %0d blocks",
               items_sent, msgs_sent, settings_used, cipher_sb.blocks_made);
      $display("%0d output bytes checked, %0d mismatches", cipher_sb.bytes_checked,
               cipher_sb.errors);
      if (cipher_sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/cc20_pkg.sv
rtl/core/cc20_req_if.sv
rtl/core/cc20_rsp_if.sv
rtl/core/cc20_qr_step.sv
rtl/core/cc20_block.sv
rtl/core/chacha20_stream_cipher_core.sv
tb/sv/cc20_cipher_check_pkg.sv
tb/sv/chacha20_stream_cipher_core_tb.sv
